// ===== hw/rtl/weighted_substring_field_scorer_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the weighted substring field scorer
// Shared property forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_SUBSTRING_FIELD_SCORER_MACROS_SVH
`define WEIGHTED_SUBSTRING_FIELD_SCORER_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet during reset.
`define WSFS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet during reset.
`define WSFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/wsfs_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted substring field scorer package
// Beat types, register indexes, field kinds and the case fold helper.
// ----------------------------------------------------------------------------
package wsfs_pkg;

  // Configuration port geometry.
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 64;

  // Register indexes on the configuration port.
  localparam logic [CFG_IW-1:0] REG_QUERY_LOW  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_QUERY_HIGH = 3'd1;
  localparam logic [CFG_IW-1:0] REG_QUERY_LEN  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_W_DISPLAY  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_W_PANEL    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_W_APP      = 3'd5;
  localparam logic [CFG_IW-1:0] REG_W_GROUP    = 3'd6;

  // Field kinds.
  localparam logic [1:0] FIELD_DISPLAY = 2'd0;
  localparam logic [1:0] FIELD_PANEL   = 2'd1;
  localparam logic [1:0] FIELD_APP     = 2'd2;
  localparam logic [1:0] FIELD_GROUP   = 2'd3;

  // Reset weights.
  localparam logic [6:0] W_DISPLAY_RST = 7'd50;
  localparam logic [6:0] W_PANEL_RST   = 7'd40;
  localparam logic [6:0] W_APP_RST     = 7'd20;
  localparam logic [6:0] W_GROUP_RST   = 7'd10;

  // The window never holds more than this many characters.
  localparam int WIN = 16;
  localparam logic [8:0] SCORE_CAP = 9'd511;

  typedef struct packed {
    logic [7:0] text_byte;
    logic [1:0] field_select;
    logic       char_valid;
    logic       last_of_field;
    logic       last_of_record;
    logic       first_of_search;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] record_number;
    logic [8:0] record_score;
    logic       listed;
    logic [4:0] slot_index;
    logic       results_full;
  } out_beat_t;

  typedef struct packed {
    logic [6:0] display;
    logic [6:0] panel;
    logic [6:0] app;
    logic [6:0] group;
  } weights_t;

  // Per-beat control broadcast along the cell row.
  typedef struct packed {
    logic       step;
    logic       flush;
    logic       clear;
    logic [7:0] text_char;
  } cell_ctl_t;

  // Per-beat control for the record tally.
  typedef struct packed {
    logic       accept;
    logic       first;
    logic       field_end;
    logic       record_end;
    logic       hit;
    logic       match_all;
    logic [1:0] kind;
  } tally_ctl_t;

  // Fold A-Z to a-z, leave every other byte alone.
  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/wsfs_cell.sv =====
// ----------------------------------------------------------------------------
// Match cell
// Compares one query character and holds a bit saying the query prefix up to
// this cell matched ending at the prior character; hands it to the next cell.
// ----------------------------------------------------------------------------
module wsfs_cell (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wsfs_pkg::cell_ctl_t   ctl_i,
  input  logic [7:0]            query_char_i,
  input  logic                  last_i,
  input  logic                  prev_i,
  output logic                  pass_o,
  output logic                  hit_o
);
  import wsfs_pkg::*;

  logic match_r;
  logic match_nxt;
  logic extend;

  // The prefix grows by one when this character matches our query byte.
  assign extend = prev_i & (ctl_i.text_char == fold_char(query_char_i));

  // A search start wipes the partial match before the beat is applied.
  assign pass_o = match_r & ~ctl_i.flush;
  assign hit_o  = ctl_i.step & extend & last_i;

  always_comb begin
    match_nxt = match_r;
    if (ctl_i.clear) begin
      match_nxt = 1'b0;
    end else if (ctl_i.step) begin
      match_nxt = extend;
    end else if (ctl_i.flush) begin
      match_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

endmodule

// ===== hw/rtl/wsfs_tally.sv =====
// ----------------------------------------------------------------------------
// Record tally
// Adds field weights, assigns result slots and holds results in a two-entry
// output stage (output register plus skid register).
// ----------------------------------------------------------------------------
module wsfs_tally #(
  parameter int MAX_RESULTS = 32,
  parameter int MAX_RECORDS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  wsfs_pkg::tally_ctl_t  ctl_i,
  input  wsfs_pkg::weights_t    weights_i,
  output logic                  busy_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output wsfs_pkg::out_beat_t   out_data_o
);
  import wsfs_pkg::*;

  localparam int RW = $clog2(MAX_RECORDS + 1);
  localparam int SW = $clog2(MAX_RESULTS + 1);

  logic          field_matched_r;
  logic [8:0]    score_r;
  logic [RW-1:0] rec_r;
  logic [SW-1:0] slots_r;
  logic          out_valid_r;
  out_beat_t     out_data_r;
  logic          skid_valid_r;
  out_beat_t     skid_data_r;

  logic          matched;
  logic [8:0]    score_base;
  logic [RW-1:0] rec_base;
  logic [SW-1:0] slots_base;
  logic [6:0]    weight;
  logic [9:0]    sum;
  logic [8:0]    score_field;
  logic          listed;
  logic [SW-1:0] slots_after;
  out_beat_t     res;
  logic          res_valid;
  logic          out_free;

  // Weight of the field kind that ends on this beat.
  always_comb begin
    case (ctl_i.kind)
      FIELD_DISPLAY: weight = weights_i.display;
      FIELD_PANEL:   weight = weights_i.panel;
      FIELD_APP:     weight = weights_i.app;
      FIELD_GROUP:   weight = weights_i.group;
      default:       weight = weights_i.group;
    endcase
  end

  // Score, slot and record count as seen after this beat.
  always_comb begin
    matched     = (field_matched_r & ~ctl_i.first) | ctl_i.hit;
    score_base  = ctl_i.first ? 9'd0 : score_r;
    rec_base    = ctl_i.first ? '0 : rec_r;
    slots_base  = ctl_i.first ? '0 : slots_r;
    sum         = {1'b0, score_base};
    if (ctl_i.field_end && (ctl_i.match_all || matched)) begin
      sum = {1'b0, score_base} + {3'd0, weight};
    end
    score_field = (sum > {1'b0, SCORE_CAP}) ? SCORE_CAP : sum[8:0];
    listed      = ctl_i.record_end && (score_field != 9'd0) &&
                  (slots_base < SW'(MAX_RESULTS)) && (rec_base < RW'(MAX_RECORDS));
    slots_after = slots_base + SW'(listed);
    res.record_number = 8'(rec_base);
    res.record_score  = score_field;
    res.listed        = listed;
    res.slot_index    = listed ? 5'(slots_base) : 5'd0;
    res.results_full  = (slots_after >= SW'(MAX_RESULTS));
    res_valid   = ctl_i.accept & ctl_i.record_end;
  end

  // Record state updates on every accepted beat.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      field_matched_r <= 1'b0;
      score_r         <= 9'd0;
      rec_r           <= '0;
      slots_r         <= '0;
    end else if (ctl_i.accept) begin
      field_matched_r <= ctl_i.field_end ? 1'b0 : matched;
      score_r         <= ctl_i.record_end ? 9'd0 : score_field;
      slots_r         <= slots_after;
      if (ctl_i.record_end && (rec_base < RW'(MAX_RECORDS))) begin
        rec_r <= rec_base + RW'(1);
      end else begin
        rec_r <= rec_base;
      end
    end
  end

  // Output register with a skid entry behind it.
  assign out_free = ~out_valid_r | ~out_stall_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r  <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : res;
    end
    if (!out_free && res_valid) begin
      skid_data_r <= res;
    end
  end

  assign busy_o      = skid_valid_r;
  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

endmodule

// ===== hw/rtl/weighted_substring_field_scorer.sv =====
// An accepted end-of-record beat registers its result in the output or skid register.
// Throughput: one input beat per cycle while in_stall is low; cells take each character.
// in_stall rises only while the skid entry behind the output register holds a result.
// Reset (rst_n low, synchronous) clears the cells and counts and restores default registers.
// ----------------------------------------------------------------------------
// Weighted substring field scorer
// Case-insensitive substring search over record fields with a row of match
// cells, weighted per-record scores and result slot assignment.
// ----------------------------------------------------------------------------
module weighted_substring_field_scorer #(
  parameter int QUERY_MAX   = 16,
  parameter int MAX_RESULTS = 32,
  parameter int MAX_RECORDS = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  wsfs_pkg::in_beat_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output wsfs_pkg::out_beat_t             out_data,
  input  logic                            cfg_we,
  input  logic [wsfs_pkg::CFG_IW-1:0]     cfg_index,
  input  logic [wsfs_pkg::CFG_DW-1:0]     cfg_wdata
);
  import wsfs_pkg::*;

  localparam int CELLS = (QUERY_MAX < WIN) ? QUERY_MAX : WIN;

  logic [63:0]    q_low_r;
  logic [63:0]    q_high_r;
  logic [4:0]     q_len_r;
  weights_t       weights_r;

  logic           accept;
  logic           busy;
  logic [4:0]     n_use;
  logic [127:0]   query_all;
  cell_ctl_t      cell_ctl;
  tally_ctl_t     tally_ctl;
  logic [CELLS:0] chain;
  logic [CELLS-1:0] hits;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_low_r           <= 64'd0;
      q_high_r          <= 64'd0;
      q_len_r           <= 5'd0;
      weights_r.display <= W_DISPLAY_RST;
      weights_r.panel   <= W_PANEL_RST;
      weights_r.app     <= W_APP_RST;
      weights_r.group   <= W_GROUP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUERY_LOW:  q_low_r           <= cfg_wdata;
        REG_QUERY_HIGH: q_high_r          <= cfg_wdata;
        REG_QUERY_LEN:  q_len_r           <= cfg_wdata[4:0];
        REG_W_DISPLAY:  weights_r.display <= cfg_wdata[6:0];
        REG_W_PANEL:    weights_r.panel   <= cfg_wdata[6:0];
        REG_W_APP:      weights_r.app     <= cfg_wdata[6:0];
        REG_W_GROUP:    weights_r.group   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Query length in use, clamped to the number of cells.
  assign n_use     = (q_len_r > 5'(CELLS)) ? 5'(CELLS) : q_len_r;
  assign query_all = {q_high_r, q_low_r};

  assign in_stall = busy;
  assign accept   = in_valid & ~busy;

  // Beat control for the cell row.
  assign cell_ctl.step      = accept & in_data.char_valid;
  assign cell_ctl.flush     = accept & in_data.first_of_search;
  assign cell_ctl.clear     = accept & (in_data.last_of_field | in_data.last_of_record);
  assign cell_ctl.text_char = fold_char(in_data.text_byte);

  // The first cell always starts a fresh prefix.
  assign chain[0] = 1'b1;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    wsfs_cell u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl_i        (cell_ctl),
      .query_char_i (query_all[8*k +: 8]),
      .last_i       (n_use == 5'(k + 1)),
      .prev_i       (chain[k]),
      .pass_o       (chain[k+1]),
      .hit_o        (hits[k])
    );
  end

  // Beat control for the record tally.
  assign tally_ctl.accept     = accept;
  assign tally_ctl.first      = in_data.first_of_search;
  assign tally_ctl.field_end  = in_data.last_of_field | in_data.last_of_record;
  assign tally_ctl.record_end = in_data.last_of_record;
  assign tally_ctl.hit        = (|hits) & (n_use != 5'd0) & (chain[CELLS] | ~chain[CELLS]);
  assign tally_ctl.match_all  = (n_use == 5'd0);
  assign tally_ctl.kind       = in_data.field_select;

  wsfs_tally #(
    .MAX_RESULTS (MAX_RESULTS),
    .MAX_RECORDS (MAX_RECORDS)
  ) u_tally (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl_i       (tally_ctl),
    .weights_i   (weights_r),
    .busy_o      (busy),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

endmodule

// ===== hw/rtl/wsfs_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker for the weighted substring field scorer
// Watches the result channel and checks the slot and score relations.
// ----------------------------------------------------------------------------
`include "weighted_substring_field_scorer_macros.svh"

module wsfs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input wsfs_pkg::out_beat_t out_data
);
  import wsfs_pkg::*;

  // A stalled result beat stays put.
  `WSFS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result beat changed while stalled")

  // Only records with a nonzero score take a slot.
  `WSFS_ASSERT_NOW(a_listed_score, out_valid && out_data.listed, out_data.record_score != 9'd0, "listed record has zero score")

  // An unlisted record reports slot zero.
  `WSFS_ASSERT_NOW(a_unlisted_slot, out_valid && !out_data.listed, out_data.slot_index == 5'd0, "unlisted record reports a slot")

endmodule

bind weighted_substring_field_scorer wsfs_checker u_wsfs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
